// ===== rtl/mss_pkg.sv =====
// Shared types and default constants for the mesh snake-order sorter.
package mss_pkg;

    localparam int SIDE_DEF = 4;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    // Datapath commands issued by the controller each cycle
    typedef struct packed {
        logic shift;  // shift grid one cell toward the head, i_key enters at tail
        logic sort;   // one odd-even transposition round along the snake path
        logic odd;    // round parity: pairs start at odd snake rank
    } t_dp_cmd;

endpackage

// ===== rtl/mesh_snake_order_sort.sv =====
// Top level: SIDE x SIDE snake-order mesh sorter.
// Load: one key word per cycle while busy is low, SIDE*SIDE words per grid.
// Sort: SIDE*SIDE transposition rounds, one per cycle, busy high.
// Emit: SIDE*SIDE result words on consecutive cycles once the last sort round is done.
// Reset (synchronous, active low) returns to load with an empty count; results never stall.
module mesh_snake_order_sort
    import mss_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    busy,
    output logic                    o_valid,
    output logic signed [KEY_W-1:0] o_sorted_key,
    output logic [POS_W-1:0]        o_position,
    output logic                    o_final_item
);

    t_dp_cmd w_cmd;

    mss_ctrl #(
        .SIDE (SIDE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .o_cmd        (w_cmd),
        .o_valid      (o_valid),
        .o_position   (o_position),
        .o_final_item (o_final_item)
    );

    mss_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_key      (i_key),
        .o_head_key (o_sorted_key)
    );

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result word while not busy");

    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_position == '0))
        else $error("emission does not start at position zero");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_item) |=> o_valid)
        else $error("emission burst broken");

    a_final_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_item) |=> (!o_valid && !busy))
        else $error("no return to load after final word");

endmodule

// ===== rtl/mss_datapath.sv =====
// Grid register row with snake-path compare-exchange network.
module mss_datapath
    import mss_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic                    i_clk,
    input  t_dp_cmd                 i_cmd,
    input  logic signed [KEY_W-1:0] i_key,
    output logic signed [KEY_W-1:0] o_head_key
);

    localparam int CELLS = SIDE * SIDE;

    logic signed [KEY_W-1:0] r_grid [CELLS];
    logic signed [KEY_W-1:0] n_grid [CELLS];

    // grid viewed in snake-rank order, before and after one round
    logic signed [KEY_W-1:0] w_rank_key  [CELLS];
    logic signed [KEY_W-1:0] w_rank_next [CELLS];
    logic signed [KEY_W-1:0] w_cell_next [CELLS];

    genvar r;
    generate
        for (r = 0; r < CELLS; r++) begin : g_rank
            localparam int ROW  = r / SIDE;
            localparam int COL  = r % SIDE;
            localparam int CIDX = ROW * SIDE + (((ROW % 2) == 1) ? (SIDE - 1 - COL) : COL);
            localparam bit PAR  = (r % 2) == 1;

            assign w_rank_key[r]     = r_grid[CIDX];
            assign w_cell_next[CIDX] = w_rank_next[r];

            if (r == 0) begin : g_first
                always_comb begin
                    w_rank_next[r] = w_rank_key[r];
                    if (i_cmd.odd == PAR && w_rank_key[r] > w_rank_key[r+1])
                        w_rank_next[r] = w_rank_key[r+1];
                end
            end else if (r == CELLS - 1) begin : g_last
                always_comb begin
                    w_rank_next[r] = w_rank_key[r];
                    if (i_cmd.odd != PAR && w_rank_key[r-1] > w_rank_key[r])
                        w_rank_next[r] = w_rank_key[r-1];
                end
            end else begin : g_mid
                always_comb begin
                    w_rank_next[r] = w_rank_key[r];
                    if (i_cmd.odd == PAR) begin
                        // lower member of pair (r, r+1): keep the min
                        if (w_rank_key[r] > w_rank_key[r+1])
                            w_rank_next[r] = w_rank_key[r+1];
                    end else begin
                        // upper member of pair (r-1, r): keep the max
                        if (w_rank_key[r-1] > w_rank_key[r])
                            w_rank_next[r] = w_rank_key[r-1];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < CELLS; i++) begin
            n_grid[i] = r_grid[i];
        end
        if (i_cmd.shift) begin
            for (int i = 0; i < CELLS - 1; i++) begin
                n_grid[i] = r_grid[i+1];
            end
            n_grid[CELLS-1] = i_key;
        end else if (i_cmd.sort) begin
            for (int i = 0; i < CELLS; i++) begin
                n_grid[i] = w_cell_next[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CELLS; i++) begin
            r_grid[i] <= n_grid[i];
        end
    end

    assign o_head_key = r_grid[0];

endmodule

// ===== rtl/mss_ctrl.sv =====
// Load / sort / emit sequencer for the snake-order sorter.
module mss_ctrl
    import mss_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output t_dp_cmd          o_cmd,
    output logic             o_valid,
    output logic [POS_W-1:0] o_position,
    output logic             o_final_item
);

    localparam int CELLS = SIDE * SIDE;
    localparam int CNT_W = $clog2(CELLS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELLS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [POS_W-1:0] r_pos,   n_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        o_cmd        = '0;
        busy         = 1'b1;
        o_valid      = 1'b0;
        o_final_item = 1'b0;
        case (r_state)
            ST_LOAD: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.shift = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        n_cnt   = '0;
                        n_state = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                o_cmd.sort = 1'b1;
                o_cmd.odd  = r_cnt[0];
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_pos   = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_valid      = 1'b1;
                o_cmd.shift  = 1'b1;
                o_final_item = (r_cnt == CNT_LAST);
                n_cnt        = r_cnt + 1'b1;
                n_pos        = r_pos + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
                n_cnt   = '0;
            end
        endcase
    end

    assign o_position = r_pos;

endmodule

// ===== verif/mesh_snake_order_sort_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the mesh snake-order sorter: random and corner grids, scoreboard check.
module mesh_snake_order_sort_tb
    import mss_pkg::*;
();

    localparam int SIDE         = SIDE_DEF;
    localparam int CELLS        = SIDE * SIDE;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * CELLS + 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
        logic                    last;
    } t_sorted_word;

    typedef enum {
        KS_FULL,     // any 32-bit pattern
        KS_NARROW,   // tiny range, lots of equal keys
        KS_CORNERS,  // only min, max, zero and minus one
        KS_RISING,   // row-major ascending
        KS_FALLING   // row-major descending
    } t_key_style;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic signed [KEY_W-1:0] i_key;
    logic                    busy;
    logic                    o_valid;
    logic signed [KEY_W-1:0] o_sorted_key;
    logic [POS_W-1:0]        o_position;
    logic                    o_final_item;

    logic signed [KEY_W-1:0] grid_keys [CELLS];
    int                      keys_loaded;
    t_sorted_word            sorted_q [$];
    int                      mismatches;
    int                      idle_cycles;
    bit                      steady_burst;

    mesh_snake_order_sort #(
        .SIDE(SIDE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_key       (i_key),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_sorted_key(o_sorted_key),
        .o_position  (o_position),
        .o_final_item(o_final_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Row-major cell that holds snake rank r
    function automatic int snake_cell(input int r);
        int row;
        int col;
        row = r / SIDE;
        col = r % SIDE;
        if (row % 2 == 1) begin
            col = SIDE - 1 - col;
        end
        return row * SIDE + col;
    endfunction

    // Ascending sort of the loaded grid, laid out along the snake path
    task automatic push_snake_grid();
        logic signed [KEY_W-1:0] ranked [CELLS];
        logic signed [KEY_W-1:0] placed [CELLS];
        logic signed [KEY_W-1:0] hold;
        int                      j;
        t_sorted_word            word;
        for (int i = 0; i < CELLS; i++) begin
            ranked[i] = grid_keys[i];
        end
        for (int i = 1; i < CELLS; i++) begin
            hold = ranked[i];
            j = i - 1;
            while (j >= 0 && ranked[j] > hold) begin
                ranked[j+1] = ranked[j];
                j--;
            end
            ranked[j+1] = hold;
        end
        for (int r = 0; r < CELLS; r++) begin
            placed[snake_cell(r)] = ranked[r];
        end
        for (int p = 0; p < CELLS; p++) begin
            word.key  = placed[p];
            word.pos  = p[POS_W-1:0];
            word.last = (p == CELLS - 1);
            sorted_q.insert(sorted_q.size(), word);
        end
    endtask

    task automatic load_key(input logic signed [KEY_W-1:0] k);
        grid_keys[keys_loaded] = k;
        keys_loaded++;
        if (keys_loaded == CELLS) begin
            push_snake_grid();
            keys_loaded = 0;
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_key(input logic signed [KEY_W-1:0] k);
        int gap;
        gap = steady_burst ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_key <= k;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        load_key(k);
        @(negedge i_clk);
    endtask

    task automatic send_grid(input t_key_style style);
        logic signed [KEY_W-1:0] k;
        steady_burst = ($urandom_range(0, 3) == 0);
        k = $urandom;
        for (int i = 0; i < CELLS; i++) begin
            case (style)
                KS_FULL: begin
                    k = $urandom;
                end
                KS_NARROW: begin
                    k = $signed($urandom_range(0, 8)) - 4;
                end
                KS_CORNERS: begin
                    case ($urandom_range(0, 3))
                        0: k = KEY_MIN;
                        1: k = KEY_MAX;
                        2: k = '0;
                        default: k = '1;
                    endcase
                end
                KS_RISING: begin
                    if (i == 0) k = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                    else k = k + $signed($urandom_range(0, 3));
                end
                KS_FALLING: begin
                    if (i == 0) k = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                    else k = k - $signed($urandom_range(0, 3));
                end
                default: begin
                    k = $urandom;
                end
            endcase
            send_key(k);
        end
    endtask

    // Extremes, equal pairs and alternating bit patterns in one full grid
    task automatic test_extreme_grid();
        logic signed [KEY_W-1:0] keys [CELLS];
        keys = '{KEY_MAX, KEY_MIN, 32'sd0, -32'sd1, 32'sd1, KEY_MIN, KEY_MAX, 32'sh5555_5555,
                 32'shAAAA_AAAA, -32'sd2, KEY_MAX - 1, KEY_MIN + 1, 32'sd0, -32'sd1, 32'sd7,
                 KEY_MAX};
        steady_burst = 1'b0;
        for (int i = 0; i < CELLS; i++) begin
            send_key(keys[i]);
        end
    endtask

    task automatic test_random_grids();
        repeat (11) send_grid(KS_FULL);
    endtask

    task automatic test_duplicate_grids();
        repeat (5) send_grid(KS_NARROW);
        repeat (2) send_grid(KS_CORNERS);
    endtask

    task automatic test_ordered_grids();
        repeat (3) send_grid(KS_RISING);
        repeat (2) send_grid(KS_FALLING);
    endtask

    always @(posedge i_clk) begin : check_results
        t_sorted_word want;
        if (i_rst_n && o_valid) begin
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected word: key %0d pos %0d final %0b",
                             o_sorted_key, o_position, o_final_item);
                end
            end else begin
                want = sorted_q.pop_front();
                if (o_sorted_key !== want.key || o_position !== want.pos
                        || o_final_item !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: exp %0d pos %0d fin %0b, got %0d pos %0d fin %0b",
                                 want.key, want.pos, want.last,
                                 o_sorted_key, o_position, o_final_item);
                    end
                end
            end
        end
    end

    // Watchdog: any accepted word in either direction counts as progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        start        = 1'b0;
        i_key        = '0;
        i_rst_n      = 1'b0;
        keys_loaded  = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        steady_burst = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_grid();
        test_random_grids();
        test_duplicate_grids();
        test_ordered_grids();

        start <= 1'b0;
        while (sorted_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sorted_q.size() != 0 || keys_loaded != 0) begin
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mss_pkg.sv
rtl/mss_datapath.sv
rtl/mss_ctrl.sv
rtl/mesh_snake_order_sort.sv
verif/mesh_snake_order_sort_tb.sv
